// File: hw/rtl/tdpt_pkg.sv
package tdpt_pkg;

  localparam int VALUE_BITS = 20;
  // trial divisor never goes past the square root plus one
  localparam int D_BITS     = (VALUE_BITS + 1) / 2 + 1;
  // running square of the divisor, one bit above the value
  localparam int SQ_BITS    = VALUE_BITS + 1;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [D_BITS-1:0]     div_t;
  typedef logic [SQ_BITS-1:0]    sq_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

// File: hw/rtl/tdpt_if.sv
interface tdpt_req_if;
  import tdpt_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;
  logic   last_in_batch;

  modport source (output valid, output value, output last_in_batch, input ready);
  modport sink   (input valid, input value, input last_in_batch, output ready);
endinterface

interface tdpt_rsp_if;
  logic valid;
  logic ready;
  logic is_prime;
  logic batch_end;

  modport source (output valid, output is_prime, output batch_end, input ready);
  modport sink   (input valid, input is_prime, input batch_end, output ready);
endinterface

// File: hw/rtl/tdpt_rem.sv
module tdpt_rem
  import tdpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  value_t      dividend,
  input  div_t        divisor,
  output rem_status_t status
);

  logic              busy;
  logic              done;
  logic [CNT_BITS-1:0] cnt;
  value_t            sh;
  div_t              rem;
  div_t              rem_next;
  logic [D_BITS:0]   trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem, sh[VALUE_BITS-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = D_BITS'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[D_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(VALUE_BITS - 1);
        sh   <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        sh  <= sh << 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule

// File: hw/rtl/trial_division_prime_test_core.sv
// channel  dir  fields                      accepted when
// req      in   value, last_in_batch        req.valid && req.ready
// rsp      out  is_prime, batch_end         rsp.valid && rsp.ready
//
// each item tries up to 1022 trial divisors at 20 bits, starting at 2 and stopping
// once the divisor passes the square root; the bit-serial remainder unit, run once
// per divisor, sets the time that an item takes.
// req.ready is high only while idle; a finished result sits in the output
// register so the next item can be taken while rsp is stalled.
// synchronous active-high reset clears the sequencer and the output valid.
module trial_division_prime_test_core
  import tdpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tdpt_req_if.sink   req,
  tdpt_rsp_if.source rsp
);

  state_t      state;
  state_t      state_next;
  value_t      n;
  logic        last;
  div_t        d;
  sq_t         sq;
  logic        res_prime;
  logic        out_valid;
  logic        out_prime;
  logic        out_last;
  logic        take_in;
  logic        div_start;
  logic        set_prime;
  logic        clr_prime;
  logic        step;
  logic        load_out;
  rem_status_t div_stat;

  tdpt_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (d),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    take_in    = 1'b0;
    div_start  = 1'b0;
    set_prime  = 1'b0;
    clr_prime  = 1'b0;
    step       = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          take_in    = 1'b1;
          // zero and one go straight out as not prime
          state_next = (req.value < VALUE_BITS'(2)) ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq > {1'b0, n}) begin
          set_prime  = 1'b1;
          state_next = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (div_stat.zero) begin
            clr_prime  = 1'b1;
            state_next = ST_DONE;
          end else begin
            step       = 1'b1;
            state_next = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (take_in) begin
      n         <= req.value;
      last      <= req.last_in_batch;
      d         <= D_BITS'(2);
      sq        <= SQ_BITS'(4);
      res_prime <= 1'b0;
    end else begin
      if (set_prime) begin
        res_prime <= 1'b1;
      end
      if (clr_prime) begin
        res_prime <= 1'b0;
      end
      if (step) begin
        // (d + 1)^2 = d^2 + 2d + 1
        d  <= d + 1'b1;
        sq <= sq + SQ_BITS'({d, 1'b1});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_prime <= res_prime;
      out_last  <= last;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.is_prime  = out_prime;
  assign rsp.batch_end = out_last;

`ifndef NO_ASSERTIONS
  a_small_not_prime: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.value < VALUE_BITS'(2)) |=>
      (state == ST_DONE && !res_prime))
    else $error("zero or one not sent straight out as not prime");

  a_div_below_root: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (sq <= {1'b0, n}))
    else $error("trial divisor started beyond the square root");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("remainder finished outside a division");

  a_prime_past_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_prime) |-> (sq > {1'b0, n}))
    else $error("prime reported before the search passed the square root");
`endif

endmodule

// File: verif/prime_result_checker.sv
`timescale 1ns / 1ps

module prime_result_checker
  import tdpt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tdpt_req_if  req,
  tdpt_rsp_if  rsp,
  output int   errors,
  output int   owed
);

  typedef struct packed {
    logic is_prime;
    logic batch_end;
  } verdict_t;

  verdict_t verdicts_due[$];
  int       fails     = 0;
  int       due_count = 0;

  assign errors = fails;
  assign owed   = due_count;

  // plain trial division up to the square root
  function automatic logic primality_of(value_t n);
    longint unsigned num;
    longint unsigned d;
    num = n;
    if (num < 2) return 1'b0;
    for (d = 2; d * d <= num; d++) begin
      if (num % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    verdict_t fresh;
    if (!rst) begin
      // compare before pushing so a result can never match its own item
      if (rsp.valid && rsp.ready) begin
        if (verdicts_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected item: expected none, actual is_prime=%0b batch_end=%0b",
                   $time, rsp.is_prime, rsp.batch_end);
        end else begin
          want = verdicts_due.pop_front();
          if (rsp.is_prime !== want.is_prime) begin
            fails++;
            $display("%0t: is_prime mismatch: expected %0b, actual %0b",
                     $time, want.is_prime, rsp.is_prime);
          end
          if (rsp.batch_end !== want.batch_end) begin
            fails++;
            $display("%0t: batch_end mismatch: expected %0b, actual %0b",
                     $time, want.batch_end, rsp.batch_end);
          end
        end
      end
      if (req.valid && req.ready) begin
        fresh.is_prime  = primality_of(req.value);
        fresh.batch_end = req.last_in_batch;
        verdicts_due.push_back(fresh);
      end
    end
    due_count = verdicts_due.size();
  end

endmodule

// File: verif/tb_trial_division_prime_test_core.sv
`timescale 1ns / 1ps

module tb_trial_division_prime_test_core;
  import tdpt_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int CALM_TAIL    = 20;
  // long enough to outlast two full-width searches
  localparam int HOLD_CYCLES  = 60_000;
  localparam int DRAIN_CYCLES = 64;
  // every item at its worst divisor search plus both sides' longest idle, times four
  localparam int LIMIT_CYCLES = 12_000_000;

  logic clk;
  logic rst;
  int   errors;
  int   owed;
  int   cycle_count;
  logic quiet;
  logic send_jittery;
  logic pressure_go;
  logic hold_rsp;

  tdpt_req_if req_ch ();
  tdpt_rsp_if rsp_ch ();

  trial_division_prime_test_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  prime_result_checker checker_i (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .errors (errors),
    .owed   (owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_trial_division_prime_test_core: errors");
    $finish;
  end

  // long receiver hold-off so the core fills up and drops req.ready
  initial begin
    hold_rsp = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_rsp = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp = 1'b0;
  end

  initial begin
    int stall_left;
    int window_left;
    logic stall_on;
    stall_left  = 0;
    window_left = 0;
    stall_on    = 1'b1;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (window_left == 0) begin
        stall_on    = ($urandom_range(0, 3) != 0);
        window_left = $urandom_range(50, 300);
      end else begin
        window_left--;
      end
      if (hold_rsp) begin
        rsp_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (!quiet && stall_on && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 19);
      end
    end
  end

  // mostly small values so the divisor search stays short, a few full width
  function automatic value_t pick_value();
    int          kind;
    int unsigned root;
    kind = $urandom_range(0, 99);
    if (kind < 45) return value_t'($urandom_range(0, 1023));
    if (kind < 70) return value_t'($urandom_range(0, 16383));
    if (kind < 80) return value_t'($urandom_range(0, 32767) * 2 + 1);
    if (kind < 90) begin
      // squares land right on the end of the search
      root = (kind < 87) ? $urandom_range(2, 255) : $urandom_range(256, 1023);
      return value_t'(root * root);
    end
    return value_t'($urandom());
  endfunction

  task automatic offer(input value_t v, input logic last);
    @(negedge clk);
    if (!quiet && send_jittery && $urandom_range(0, 3) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_ch.valid         = 1'b1;
    req_ch.value         = v;
    req_ch.last_in_batch = last;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  initial begin
    value_t lead [$];
    rst                  = 1'b1;
    quiet                = 1'b0;
    send_jittery         = 1'b1;
    pressure_go          = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.value         = '0;
    req_ch.last_in_batch = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero and one, the first primes, squares at the search boundary, width extremes
    lead = '{20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd5, 20'd9, 20'd25, 20'd49,
             20'd97, 20'd121, 20'hFFFFF, 20'hFFFFE, 20'd1048573, 20'd999983,
             20'h80000, 20'h55555, 20'hAAAAA, 20'd1042441, 20'd65521};
    foreach (lead[i]) offer(lead[i], logic'(i % 3 == 2));

    pressure_go = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_TAIL) quiet = 1'b1;
      if (i % 10 == 0) send_jittery = ($urandom_range(0, 2) != 0);
      offer(pick_value(), logic'($urandom_range(0, 3) == 0));
    end
    @(negedge clk);
    req_ch.valid = 1'b0;

    wait (owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && owed == 0) begin
      $display("tb_trial_division_prime_test_core: clean");
    end else begin
      $display("tb_trial_division_prime_test_core: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_if.sv
hw/rtl/tdpt_rem.sv
hw/rtl/trial_division_prime_test_core.sv
verif/prime_result_checker.sv
verif/tb_trial_division_prime_test_core.sv
